[src/bes_pkg.sv]
// ============================================================================
// bes_pkg
// Shared types, constants and the sequencer program of the Burgers
// stencil step block.
// ============================================================================
package bes_pkg;

    // Field widths and fixed-point defaults
    localparam int DATA_W        = 32;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int CFG_IDX_W     = 2;
    localparam int FRAC_BITS_DEF = 24;

    localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Program counter
    localparam int PROG_LEN = 12;
    localparam int PC_W     = $clog2(PROG_LEN);
    typedef logic [PC_W-1:0] t_pc;

    // Named step addresses used as jump targets
    localparam t_pc STEP_CHECK_LAST = t_pc'(9);
    localparam t_pc STEP_SHIFT      = t_pc'(11);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER   = 2'd0,
        CFG_NEIGHBOR = 2'd1,
        CFG_ADVECT   = 2'd2
    } t_cfg_idx;

    // Multiplier operand pairs
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_RR,
        MUL_LL,
        MUL_BC,
        MUL_AL,
        MUL_AR,
        MUL_KSR,
        MUL_KSL
    } t_mul_sel;

    // Write-back action on the product of the previous step
    typedef enum logic [2:0] {
        WB_NONE,
        WB_SQR,
        WB_SQL,
        WB_LOAD,
        WB_ADD,
        WB_SUB
    } t_wb_op;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_UPDATE,
        EMIT_PASS
    } t_emit_op;

    typedef enum logic [1:0] {
        WIN_HOLD,
        WIN_CLEAR,
        WIN_SHIFT
    } t_win_op;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_NO_CENTER,
        COND_NOT_LAST
    } t_cond;

    // One control word of the program
    typedef struct packed {
        t_mul_sel mul_sel;
        t_wb_op   wb_op;
        t_emit_op emit_op;
        t_win_op  win_op;
        t_cond    cond;
        t_pc      target;
        logic     done;
    } t_ctrl_word;

    // Control word qualified by step enable
    typedef struct packed {
        logic       en;
        t_ctrl_word word;
    } t_step;

    // Status from datapath to sequencer
    typedef struct packed {
        logic center_valid;
        logic last;
    } t_flags;

    // One result beat
    typedef struct packed {
        logic signed [DATA_W-1:0] new_value;
        logic                     row_end;
        logic                     saturated;
    } t_result;

    // Configuration write
    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [DATA_W-1:0]    data;
    } t_cfg_wr;

    localparam t_ctrl_word CTRL_NOP = '{
        mul_sel: MUL_NONE, wb_op: WB_NONE, emit_op: EMIT_NONE,
        win_op: WIN_HOLD, cond: COND_NONE, target: '0, done: 1'b0
    };

    // Program ROM: squares, five weighted terms, emit, window update
    function automatic t_ctrl_word prog_word(input t_pc pc);
        t_ctrl_word w;
        w = CTRL_NOP;
        unique case (pc)
            t_pc'(0): begin
                w.mul_sel = MUL_RR;
                w.cond    = COND_NO_CENTER;
                w.target  = STEP_CHECK_LAST;
            end
            t_pc'(1): begin
                w.mul_sel = MUL_LL;
                w.wb_op   = WB_SQR;
            end
            t_pc'(2): begin
                w.mul_sel = MUL_BC;
                w.wb_op   = WB_SQL;
            end
            t_pc'(3): begin
                w.mul_sel = MUL_AL;
                w.wb_op   = WB_LOAD;
            end
            t_pc'(4): begin
                w.mul_sel = MUL_AR;
                w.wb_op   = WB_ADD;
            end
            t_pc'(5): begin
                w.mul_sel = MUL_KSR;
                w.wb_op   = WB_ADD;
            end
            t_pc'(6): begin
                w.mul_sel = MUL_KSL;
                w.wb_op   = WB_SUB;
            end
            t_pc'(7): begin
                w.wb_op   = WB_ADD;
            end
            t_pc'(8): begin
                w.emit_op = EMIT_UPDATE;
            end
            t_pc'(9): begin
                w.cond    = COND_NOT_LAST;
                w.target  = STEP_SHIFT;
            end
            t_pc'(10): begin
                w.emit_op = EMIT_PASS;
                w.win_op  = WIN_CLEAR;
                w.done    = 1'b1;
            end
            t_pc'(11): begin
                w.win_op  = WIN_SHIFT;
                w.done    = 1'b1;
            end
            default: begin
                w.done    = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

[src/bes_if.sv]
// ============================================================================
// bes_if
// Valid/ready channels of the stencil step block: samples in, results
// out, coefficient writes.
// ============================================================================
interface bes_in_if import bes_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sample;
    logic                     last_point;

    modport source (output valid, output sample, output last_point, input ready);
    modport sink   (input valid, input sample, input last_point, output ready);
endinterface

interface bes_out_if import bes_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] new_value;
    logic                     row_end;
    logic                     saturated;

    modport source (output valid, output new_value, output row_end, output saturated,
                    input ready);
    modport sink   (input valid, input new_value, input row_end, input saturated,
                    output ready);
endinterface

interface bes_cfg_if import bes_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/bes_seq.sv]
// ============================================================================
// bes_seq
// Microcode sequencer: step counter, program ROM, conditional jumps and
// stall on a busy output register.
// ============================================================================
module bes_seq import bes_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  logic   i_out_free,
    input  t_flags i_flags,
    output logic   o_busy,
    output t_step  o_step
);

    logic       r_busy, n_busy;
    t_pc        r_pc, n_pc;
    t_ctrl_word w;
    logic       step_en;
    logic       cond_hit;

    // Fetch and qualify the current word
    assign w       = prog_word(r_pc);
    assign step_en = r_busy && ((w.emit_op == EMIT_NONE) || i_out_free);

    // Jump condition decode
    always_comb begin
        unique case (w.cond)
            COND_NONE:      cond_hit = 1'b0;
            COND_NO_CENTER: cond_hit = !i_flags.center_valid;
            COND_NOT_LAST:  cond_hit = !i_flags.last;
            default:        cond_hit = 1'b0;
        endcase
    end

    // Next step
    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (i_start) begin
            n_busy = 1'b1;
            n_pc   = '0;
        end else if (step_en) begin
            if (w.done) begin
                n_busy = 1'b0;
                n_pc   = '0;
            end else if (cond_hit) begin
                n_pc   = w.target;
            end else begin
                n_pc   = r_pc + t_pc'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    assign o_busy      = r_busy;
    assign o_step.en   = step_en;
    assign o_step.word = w;

endmodule

[src/bes_dp.sv]
// ============================================================================
// bes_dp
// Datapath: coefficients, three-point window, one shared multiplier,
// rounding, square clip, accumulator and result saturation.
// ============================================================================
module bes_dp import bes_pkg::*; #(
    parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  logic signed [DATA_W-1:0] i_sample,
    input  logic                     i_last,
    input  t_cfg_wr                  i_cfg,
    input  t_step                    i_step,
    output t_flags                   o_flags,
    output t_result                  o_result
);

    localparam int MW = DATA_W + 1;
    localparam int AW = PROD_W - FRACTION_BITS + 3;
    localparam logic signed [PROD_W-1:0] HALF =
        {{(PROD_W-1){1'b0}}, 1'b1} << (FRACTION_BITS - 1);

    logic signed [DATA_W-1:0] r_coef_center, r_coef_neighbor, r_coef_advect;
    logic signed [DATA_W-1:0] r_left, r_center, r_sample;
    logic                     r_center_valid, r_last;
    logic        [DATA_W-2:0] r_sqr, r_sql;
    logic                     r_sq_clip;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [AW-1:0]     r_acc;

    logic signed [MW-1:0]     mul_a, mul_b;
    logic signed [2*MW-1:0]   mul_p;
    logic signed [PROD_W-1:0] rnd_full;
    logic signed [AW-1:0]     rnd_acc;
    logic                     sq_over;
    logic        [DATA_W-2:0] sq_val;
    logic                     acc_hi, acc_lo;
    t_ctrl_word               w;

    assign w = i_step.word;

    // Coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_center   <= '0;
            r_coef_neighbor <= '0;
            r_coef_advect   <= '0;
        end else if (i_cfg.we) begin
            case (i_cfg.index)
                CFG_CENTER:   r_coef_center   <= i_cfg.data;
                CFG_NEIGHBOR: r_coef_neighbor <= i_cfg.data;
                CFG_ADVECT:   r_coef_advect   <= i_cfg.data;
                default:      ;
            endcase
        end
    end

    // Incoming sample latch
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sample <= i_sample;
            r_last   <= i_last;
        end
    end

    // Window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left         <= '0;
            r_center       <= '0;
            r_center_valid <= 1'b0;
        end else if (i_step.en) begin
            case (w.win_op)
                WIN_CLEAR: begin
                    r_left         <= '0;
                    r_center       <= '0;
                    r_center_valid <= 1'b0;
                end
                WIN_SHIFT: begin
                    r_left         <= r_center_valid ? r_center : '0;
                    r_center       <= r_sample;
                    r_center_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (w.mul_sel)
            MUL_RR:  begin mul_a = MW'(r_sample);        mul_b = MW'(r_sample); end
            MUL_LL:  begin mul_a = MW'(r_left);          mul_b = MW'(r_left);   end
            MUL_BC:  begin mul_a = MW'(r_coef_center);   mul_b = MW'(r_center); end
            MUL_AL:  begin mul_a = MW'(r_coef_neighbor); mul_b = MW'(r_left);   end
            MUL_AR:  begin mul_a = MW'(r_coef_neighbor); mul_b = MW'(r_sample); end
            MUL_KSR: begin
                mul_a = MW'(r_coef_advect);
                mul_b = signed'({2'b00, r_sqr});
            end
            MUL_KSL: begin
                mul_a = MW'(r_coef_advect);
                mul_b = signed'({2'b00, r_sql});
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (i_step.en) begin
            r_prod <= mul_p[PROD_W-1:0];
        end
    end

    // Round half up to FRACTION_BITS; squares clip at the positive limit
    assign rnd_full = (r_prod + HALF) >>> FRACTION_BITS;
    assign rnd_acc  = AW'(rnd_full);
    assign sq_over  = rnd_full > PROD_W'(S32_MAX);
    assign sq_val   = sq_over ? S32_MAX[DATA_W-2:0] : rnd_full[DATA_W-2:0];

    // Write-back of the previous product
    always_ff @(posedge i_clk) begin
        if (i_step.en) begin
            case (w.wb_op)
                WB_SQR:  r_sqr <= sq_val;
                WB_SQL:  r_sql <= sq_val;
                WB_LOAD: r_acc <= rnd_acc;
                WB_ADD:  r_acc <= r_acc + rnd_acc;
                WB_SUB:  r_acc <= r_acc - rnd_acc;
                default: ;
            endcase
        end
    end

    // Square clip flag, cleared per sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_clip <= 1'b0;
        end else if (i_load) begin
            r_sq_clip <= 1'b0;
        end else if (i_step.en && sq_over &&
                     ((w.wb_op == WB_SQR) || (w.wb_op == WB_SQL))) begin
            r_sq_clip <= 1'b1;
        end
    end

    // Result select
    assign acc_hi = r_acc > AW'(S32_MAX);
    assign acc_lo = r_acc < AW'(S32_MIN);

    always_comb begin
        if (w.emit_op == EMIT_PASS) begin
            o_result.new_value = r_sample;
            o_result.row_end   = 1'b1;
            o_result.saturated = 1'b0;
        end else begin
            if (acc_hi) begin
                o_result.new_value = S32_MAX;
            end else if (acc_lo) begin
                o_result.new_value = S32_MIN;
            end else begin
                o_result.new_value = r_acc[DATA_W-1:0];
            end
            o_result.row_end   = 1'b0;
            o_result.saturated = (r_sq_clip && (r_coef_advect != '0)) || acc_hi || acc_lo;
        end
    end

    assign o_flags.center_valid = r_center_valid;
    assign o_flags.last         = r_last;

endmodule

[src/burgers_explicit_stencil_step.sv]
// ============================================================================
// burgers_explicit_stencil_step
// One explicit viscous Burgers time step over a streamed grid row.
// ============================================================================
// Usage:
//   i_in_bus  : grid samples of a row in order, last_point marks the end.
//   o_out_bus : updated values, one beat per point, lagging by one sample;
//               row_end marks the final point, saturated flags clipping.
//   i_cfg_bus : coefficient writes (0 center B, 1 neighbor A, 2 advect K),
//               always ready; write only while no sample is in work.
// Timing:
//   One sample is in work at a time. A sample with a held center takes
//   11 steps, the first of a row 3, and ready returns in the cycle after
//   the last step. The step count is set by the seven products of an
//   update sharing one multiplier. The update result enters the output
//   register at the emit step.
// Reset:
//   Synchronous, active low; clears coefficients, window and output valid.
// Stall:
//   A result waits in the output register; the sequencer holds at an emit
//   step while that register is full and not being drained.
// ============================================================================
module burgers_explicit_stencil_step import bes_pkg::*; #(
    parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bes_in_if.sink    i_in_bus,
    bes_out_if.source o_out_bus,
    bes_cfg_if.sink   i_cfg_bus
);

    logic    busy;
    logic    in_load;
    logic    out_free;
    logic    emit;
    t_step   step;
    t_flags  flags;
    t_result result;
    t_cfg_wr cfg;
    t_result r_out;
    logic    r_out_valid;

    // Input and configuration handshakes
    assign i_in_bus.ready  = !busy;
    assign in_load         = i_in_bus.valid && !busy;
    assign i_cfg_bus.ready = 1'b1;
    assign cfg.we          = i_cfg_bus.valid;
    assign cfg.index       = i_cfg_bus.index;
    assign cfg.data        = i_cfg_bus.data;

    assign out_free = !r_out_valid || o_out_bus.ready;
    assign emit     = step.en && (step.word.emit_op != EMIT_NONE);

    bes_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_load),
        .i_out_free (out_free),
        .i_flags    (flags),
        .o_busy     (busy),
        .o_step     (step)
    );

    bes_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_load),
        .i_sample (i_in_bus.sample),
        .i_last   (i_in_bus.last_point),
        .i_cfg    (cfg),
        .i_step   (step),
        .o_flags  (flags),
        .o_result (result)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out_bus.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= result;
        end
    end

    assign o_out_bus.valid     = r_out_valid;
    assign o_out_bus.new_value = r_out.new_value;
    assign o_out_bus.row_end   = r_out.row_end;
    assign o_out_bus.saturated = r_out.saturated;

endmodule
